[rtl/smx_pkg.sv]
// smx_pkg: opcodes, status codes, controller states and the request struct
// shared by the stack machine execute unit. No dependencies.
package smx_pkg;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,  OP_PUSHR = 5'd1,  OP_POP  = 5'd2,  OP_POPR = 5'd3,
    OP_SQRT  = 5'd4,  OP_RET   = 5'd5,  OP_IN   = 5'd6,  OP_JMP  = 5'd7,
    OP_CALL  = 5'd8,  OP_ADD   = 5'd9,  OP_SUB  = 5'd10, OP_MUL  = 5'd11,
    OP_DIV   = 5'd12, OP_MOD   = 5'd13, OP_JB   = 5'd14, OP_JBE  = 5'd15,
    OP_JA    = 5'd16, OP_JAE   = 5'd17, OP_JE   = 5'd18, OP_JNE  = 5'd19,
    OP_OUT   = 5'd20, OP_OUTC  = 5'd21, OP_PUSHM = 5'd22, OP_POPM = 5'd23,
    OP_HLT   = 5'd24
  } opcode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_NEGSQRT   = 3'd4;
  localparam logic [2:0] ST_BADTGT    = 3'd5;
  localparam logic [2:0] ST_HALT      = 3'd6;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_CHR  = 2'd2;

  localparam logic [16:0] CODE_LEN_RESET = 17'd65536;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MEM, S_EXEC, S_ITER, S_DONE
  } state_t;

  // request to the iterative arithmetic unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic        want_mod;
    logic [31:0] a;
    logic [31:0] b;
  } itu_req_t;

endpackage

[rtl/stack_machine_execute_unit.sv]
// stack_machine_execute_unit: top level, sequencer and state memories.
// Depends on smx_pkg and smx_iter_unit.
//
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_ready  | action, operand, in_value
// out_    | out | out_valid/out_ready| next_pc, out_kind, out_value, status
// cfg_    | in  | APB psel/penable   | code_length at address 0
//
// One instruction at a time. Simple ops pass through accept, stack/register
// read, RAM read, execute and result. div/mod and sqrt also iterate in the
// bit-serial unit (32 quotient bits, 16 root bits). Reset is synchronous;
// RAM and register file are cleared by a sweep over
// max(RAM_WORDS,REGISTER_COUNT) addresses after reset, during which no item
// is accepted. A stalled result holds in the output register; the next item
// is taken in the cycle it leaves.
module stack_machine_execute_unit import smx_pkg::*; #(
  parameter int DATA_STACK_DEPTH   = 64,
  parameter int RETURN_STACK_DEPTH = 32,
  parameter int REGISTER_COUNT     = 8,
  parameter int RAM_WORDS          = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         in_action,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_next_pc,
  output logic [1:0]         out_out_kind,
  output logic signed [31:0] out_out_value,
  output logic [2:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int DSW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int DAW = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
  localparam int RSW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int RAW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
  localparam int RGW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int MW  = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int CLRN = (RAM_WORDS > REGISTER_COUNT) ? RAM_WORDS : REGISTER_COUNT;
  localparam int CW  = $clog2(CLRN + 1);

  // configuration
  logic [16:0] code_len_r;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {15'd0, code_len_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) code_len_r <= CODE_LEN_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0) code_len_r <= pwdata[16:0];
  end

  // memories
  logic [31:0] dstk   [DATA_STACK_DEPTH];
  logic [15:0] rstk   [RETURN_STACK_DEPTH];
  logic [31:0] regf   [REGISTER_COUNT];
  logic [31:0] dmem   [RAM_WORDS];
  logic [31:0] d0_r, d1_r, rg_r, dm_r;
  logic [15:0] rs_r;

  state_t state_r, state_nxt;
  logic [15:0] pc_r;
  logic [DSW-1:0] dcnt_r;
  logic [RSW-1:0] rcnt_r;
  logic [CW-1:0]  clr_r;
  logic [4:0]  op_r;
  logic [31:0] opd_r, inv_r;
  itu_req_t    ireq;
  logic        idone;
  logic [31:0] ires;

  smx_iter_unit u_iter (.clk(clk), .rst_n(rst_n), .req(ireq), .done(idone), .result(ires));

  logic [DAW-1:0] top_a, sec_a;
  logic [RGW-1:0] ridx;
  assign top_a = DAW'(dcnt_r - DSW'(1));
  assign sec_a = DAW'(dcnt_r - DSW'(2));
  assign ridx  = RGW'(opd_r % REGISTER_COUNT);

  // execute decode
  logic [15:0] npc1, npc2, tgt;
  logic        bad_tgt, full, cond, rfull;
  logic [31:0] mul_v;
  assign npc1 = pc_r + 16'd1;
  assign npc2 = pc_r + 16'd2;
  assign tgt  = opd_r[15:0];
  assign bad_tgt = opd_r[31] || (opd_r >= {15'd0, code_len_r}) || (opd_r[31:16] != 16'd0);
  assign full  = dcnt_r >= DSW'(DATA_STACK_DEPTH);
  assign rfull = rcnt_r >= RSW'(RETURN_STACK_DEPTH);
  assign mul_v = d1_r * d0_r;

  always_comb begin
    cond = 1'b0;
    case (op_r)
      OP_JB:  cond = $signed(d1_r) <  $signed(d0_r);
      OP_JBE: cond = $signed(d1_r) <= $signed(d0_r);
      OP_JA:  cond = $signed(d1_r) >  $signed(d0_r);
      OP_JAE: cond = $signed(d1_r) >= $signed(d0_r);
      OP_JE:  cond = d1_r == d0_r;
      default: cond = d1_r != d0_r;
    endcase
  end

  // execute outcome
  logic [2:0]  st;
  logic [15:0] npc;
  logic [1:0]  kind;
  logic [31:0] oval;
  logic        ds_we, rs_we, rg_we, dm_we, go_iter;
  logic [DAW-1:0] ds_wa;
  logic [31:0] ds_wd;
  logic [DSW-1:0] dcnt_new;
  logic [RSW-1:0] rcnt_new;

  always_comb begin
    st = ST_OK; npc = npc1; kind = KIND_NONE; oval = 32'd0;
    ds_we = 1'b0; rs_we = 1'b0; rg_we = 1'b0; dm_we = 1'b0; go_iter = 1'b0;
    ds_wa = top_a; ds_wd = 32'd0; dcnt_new = dcnt_r; rcnt_new = rcnt_r;
    case (op_r)
      OP_PUSH, OP_PUSHR, OP_IN, OP_PUSHM: begin
        if (full) st = ST_OVERFLOW;
        else begin
          ds_we = 1'b1; ds_wa = DAW'(dcnt_r); dcnt_new = dcnt_r + DSW'(1);
          case (op_r)
            OP_PUSH:  ds_wd = opd_r;
            OP_PUSHR: ds_wd = rg_r;
            OP_IN:    ds_wd = inv_r;
            default:  ds_wd = dm_r;
          endcase
          if (op_r != OP_IN) npc = npc2;
        end
      end
      OP_POP, OP_POPR, OP_OUT, OP_OUTC, OP_POPM: begin
        if (dcnt_r == '0) st = ST_UNDERFLOW;
        else begin
          dcnt_new = dcnt_r - DSW'(1);
          if (op_r == OP_POPR) begin rg_we = 1'b1; npc = npc2; end
          else if (op_r == OP_POPM) begin dm_we = 1'b1; npc = npc2; end
          else if (op_r == OP_OUT) begin kind = KIND_NUM; oval = d0_r; end
          else if (op_r == OP_OUTC) begin kind = KIND_CHR; oval = d0_r; end
        end
      end
      OP_SQRT: begin
        if (dcnt_r == '0) st = ST_UNDERFLOW;
        else if (d0_r[31]) st = ST_NEGSQRT;
        else go_iter = 1'b1;
      end
      OP_RET: begin
        if (rcnt_r == '0) st = ST_UNDERFLOW;
        else begin npc = rs_r; rcnt_new = rcnt_r - RSW'(1); end
      end
      OP_JMP: begin
        if (bad_tgt) st = ST_BADTGT; else npc = tgt;
      end
      OP_CALL: begin
        if (bad_tgt) st = ST_BADTGT;
        else if (rfull) st = ST_OVERFLOW;
        else begin rs_we = 1'b1; rcnt_new = rcnt_r + RSW'(1); npc = tgt; end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (dcnt_r < DSW'(2)) st = ST_UNDERFLOW;
        else if ((op_r == OP_DIV || op_r == OP_MOD) && d0_r == 32'd0) st = ST_DIVZERO;
        else if (op_r == OP_DIV || op_r == OP_MOD) go_iter = 1'b1;
        else begin
          ds_we = 1'b1; ds_wa = sec_a; dcnt_new = dcnt_r - DSW'(1);
          case (op_r)
            OP_ADD:  ds_wd = d1_r + d0_r;
            OP_SUB:  ds_wd = d1_r - d0_r;
            default: ds_wd = mul_v;
          endcase
        end
      end
      OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
        if (bad_tgt) st = ST_BADTGT;
        else if (dcnt_r < DSW'(2)) st = ST_UNDERFLOW;
        else begin dcnt_new = dcnt_r - DSW'(2); npc = cond ? tgt : npc2; end
      end
      OP_HLT: st = ST_HALT;
      default: ;
    endcase
    if (st != ST_OK) npc = pc_r;
  end

  assign ireq.start    = (state_r == S_EXEC) && go_iter && (st == ST_OK);
  assign ireq.is_sqrt  = (op_r == OP_SQRT);
  assign ireq.want_mod = (op_r == OP_MOD);
  assign ireq.a        = (op_r == OP_SQRT) ? d0_r : d1_r;
  assign ireq.b        = d0_r;

  // next item only in idle, after the clear sweep, once the result register is free
  assign in_ready = (state_r == S_IDLE) && (clr_r == CW'(CLRN)) &&
                    (!out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_READ;
      S_READ: state_nxt = S_MEM;
      S_MEM:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = (go_iter && st == ST_OK) ? S_ITER : S_DONE;
      S_ITER: if (idone) state_nxt = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pc_r <= '0; dcnt_r <= '0; rcnt_r <= '0;
      clr_r <= '0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r != CW'(CLRN)) clr_r <= clr_r + CW'(1);
      if (state_r == S_DONE && state_nxt == S_IDLE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (state_r == S_EXEC) begin
        dcnt_r <= dcnt_new; rcnt_r <= rcnt_new;
        out_next_pc <= npc; out_out_kind <= kind;
        out_out_value <= oval; out_status <= st;
        if (!(go_iter && st == ST_OK)) pc_r <= npc;
      end
      if (state_r == S_ITER && idone) begin
        if (op_r != OP_SQRT) dcnt_r <= dcnt_r - DSW'(1);
        pc_r <= npc1; out_next_pc <= npc1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_action; opd_r <= in_operand; inv_r <= in_in_value;
    end
  end

  // memory ports: reads registered, at most one write per memory in any cycle
  logic [MW-1:0] maddr;
  assign maddr = MW'(rg_r % RAM_WORDS);
  always_ff @(posedge clk) begin
    d0_r <= dstk[top_a];
    d1_r <= dstk[sec_a];
    rs_r <= rstk[RAW'(rcnt_r - RSW'(1))];
    if (state_r == S_READ) rg_r <= regf[ridx];
    dm_r <= dmem[maddr];
    if (state_r == S_EXEC && ds_we) dstk[ds_wa] <= ds_wd;
    if (state_r == S_ITER && idone) dstk[(op_r == OP_SQRT) ? top_a : sec_a] <= ires;
    if (state_r == S_EXEC && rs_we) rstk[RAW'(rcnt_r)] <= npc2;
    if (clr_r != CW'(CLRN)) begin
      if (clr_r < CW'(REGISTER_COUNT)) regf[RGW'(clr_r)] <= 32'd0;
      if (clr_r < CW'(RAM_WORDS)) dmem[MW'(clr_r)] <= 32'd0;
    end else begin
      if (state_r == S_EXEC && rg_we) regf[ridx] <= d0_r;
      if (state_r == S_EXEC && dm_we) dmem[maddr] <= d0_r;
    end
  end
endmodule

[rtl/smx_iter_unit.sv]
// smx_iter_unit: bit-serial signed divide/modulo and rounded square root.
// Depends on smx_pkg. One bit per cycle; 32 quotient bits for divide, 16 root bits for sqrt.
module smx_iter_unit import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  itu_req_t    req,
  output logic        done,
  output logic [31:0] result
);
  logic        busy_r, sqrt_r, mod_r, na_r, nq_r;
  logic [5:0]  cnt_r;
  logic [31:0] num_r, den_r, quo_r, rem_r, x_r;
  logic [32:0] trial;
  logic [33:0] strial;
  logic [33:0] srem;
  logic [31:0] ma, mb;
  logic [31:0] root_fix;

  assign ma = req.a[31] ? 32'd0 - req.a : req.a;
  assign mb = req.b[31] ? 32'd0 - req.b : req.b;
  // divide: shift in next dividend bit
  assign trial  = {rem_r, num_r[31]} - {1'b0, den_r};
  // sqrt: remainder with two new bits, trial = 4q+1 (q the partial root)
  assign srem   = {rem_r, num_r[31:30]};
  assign strial = srem - {quo_r, 2'b01};
  assign root_fix = ((x_r - quo_r * quo_r) > quo_r) ? quo_r + 32'd1 : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        sqrt_r <= req.is_sqrt;
        mod_r  <= req.want_mod;
        na_r   <= req.a[31];
        nq_r   <= req.a[31] ^ req.b[31];
        num_r  <= req.is_sqrt ? req.a : ma;
        x_r    <= req.a;
        den_r  <= mb;
        quo_r  <= '0;
        rem_r  <= '0;
        cnt_r  <= req.is_sqrt ? 6'd16 : 6'd32;
      end else if (busy_r) begin
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          if (sqrt_r)      result <= root_fix;
          else if (mod_r)  result <= na_r ? 32'd0 - rem_r : rem_r;
          else             result <= nq_r ? 32'd0 - quo_r : quo_r;
        end else begin
          cnt_r <= cnt_r - 6'd1;
          if (sqrt_r) begin
            num_r <= {num_r[29:0], 2'b00};
            if (!strial[33]) begin
              rem_r <= strial[31:0];
              quo_r <= {quo_r[30:0], 1'b1};
            end else begin
              rem_r <= srem[31:0];
              quo_r <= {quo_r[30:0], 1'b0};
            end
          end else begin
            num_r <= {num_r[30:0], 1'b0};
            if (!trial[32]) begin
              rem_r <= trial[31:0];
              quo_r <= {quo_r[30:0], 1'b1};
            end else begin
              rem_r <= {rem_r[30:0], num_r[31]};
              quo_r <= {quo_r[30:0], 1'b0};
            end
          end
        end
      end
    end
  end
endmodule

[rtl/smx_checker.sv]
// smx_checker: port-level assertions for stack_machine_execute_unit.
// Depends on smx_pkg; bound to the top level below.
module smx_checker import smx_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_next_pc,
  input logic [1:0]  out_out_kind,
  input logic [31:0] out_out_value,
  input logic [2:0]  out_status
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc))
    else $error("result dropped while stalled");
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_out_kind == KIND_NONE && out_out_value == 32'd0)
    else $error("output on error");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_out_kind != 2'd3 && out_status <= ST_HALT)
    else $error("bad result code");
endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_next_pc(out_next_pc),
  .out_out_kind(out_out_kind), .out_out_value(out_out_value), .out_status(out_status));
